// ===== design/edid_pkg.sv =====
// Package for the display identification block decoder.
// Result kinds, register indexes, widths and fixed byte offsets. No dependencies.
package edid_pkg;
    localparam int BLOCK_BYTES      = 128;
    localparam int DESCRIPTOR_COUNT = 4;
    localparam int TIMING_SLOTS     = 8;
    localparam int ADDR_W           = 7;

    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_IDENT  = 3'd1;
    localparam logic [2:0] KIND_DATE   = 3'd2;
    localparam logic [2:0] KIND_DISP   = 3'd3;
    localparam logic [2:0] KIND_LIMITS = 3'd4;
    localparam logic [2:0] KIND_TIMING = 3'd5;

    localparam logic REG_REQ_CKS   = 1'b0;
    localparam logic REG_SKIP_HDR  = 1'b1;

    localparam logic [7:0] RANGE_TAG   = 8'hfd;
    localparam logic [7:0] DESC_BASE   = 8'h36;
    localparam logic [7:0] DESC_STRIDE = 8'd18;
    localparam logic [7:0] TIMING_BASE = 8'h26;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [15:0] a;
        logic [15:0] b;
        logic [31:0] c;
        logic [15:0] d;
        logic        last;
    } t_result;
endpackage

// ===== design/edid_store.sv =====
// Byte store of the block: 128 x 8 synchronous memory, one write and one read port.
// Uses edid_pkg.
module edid_store #(
    parameter int BLOCK_BYTES = edid_pkg::BLOCK_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(BLOCK_BYTES)-1:0] i_waddr,
    input  logic [7:0]                     i_wdata,
    input  logic [$clog2(BLOCK_BYTES)-1:0] i_raddr,
    output logic [7:0]                     o_rdata
);
    logic [7:0] r_mem [BLOCK_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/edid_base_block_decoder.sv =====
// Top level of the display identification block decoder.
// Collects bytes into edid_store, then walks the store to build the result items.
// Depends on edid_pkg and edid_store.
//
//  channel  | handshake              | payload
//  input    | i_start / o_busy       | i_edid_byte, i_first_byte
//  config   | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//  result   | o_strobe               | o_kind, o_value_a..d, o_last
//
// One byte per cycle while collecting. After byte 127 the block stays busy while it reads
// the fixed bytes, emits identity and date, searches the descriptors, reads the range bytes
// (skipped when none matches) and reads the two bytes of each timing slot.
// Results leave at most one per cycle and cannot be held off. Config is taken only when idle.
// Reset is synchronous; the store is not cleared.
module edid_base_block_decoder #(
    parameter int BLOCK_BYTES      = edid_pkg::BLOCK_BYTES,
    parameter int DESCRIPTOR_COUNT = edid_pkg::DESCRIPTOR_COUNT,
    parameter int TIMING_SLOTS     = edid_pkg::TIMING_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [7:0]  i_edid_byte,
    input  logic        i_first_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [15:0] o_value_a,
    output logic [15:0] o_value_b,
    output logic [31:0] o_value_c,
    output logic [15:0] o_value_d,
    output logic        o_last
);
    localparam int AW = $clog2(BLOCK_BYTES);

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_FIXED   = 3'd1;
    localparam logic [2:0] S_IDENT   = 3'd2;
    localparam logic [2:0] S_DATE    = 3'd3;
    localparam logic [2:0] S_DESC    = 3'd4;
    localparam logic [2:0] S_RANGE   = 3'd5;
    localparam logic [2:0] S_TIMING  = 3'd6;

    logic [2:0]    r_state;
    logic [AW-1:0] r_off;
    logic [7:0]    r_sum;
    logic          r_hdr;
    logic          r_req_cks, r_skip_hdr;
    logic [5:0]    r_step;
    logic [5:0]    n_step;
    logic [7:0]    r_b [30];
    logic [7:0]    r_dsc [5];
    logic [7:0]    r_rng [4];
    logic [1:0]    r_desc;
    logic          r_found;
    logic [7:0]    r_fbase;
    logic [2:0]    r_slot;
    logic [7:0]    r_t0;
    logic [15:0]   r_h;
    logic          r_hpend;
    logic [1:0]    r_asp;
    logic [5:0]    r_rf;
    logic          r_used;
    logic [AW-1:0] n_raddr;
    logic          r_rvalid;
    logic [4:0]    r_rtag;
    logic [4:0]    n_rtag;
    logic          n_rreq;
    logic [7:0]    w_rdata;
    logic [7:0]    w_a8;
    edid_pkg::t_result r_res;

    logic          acc_in;
    logic          w_hdr_ok;
    logic [7:0]    want;
    logic [AW-1:0] w_off;
    logic [7:0]    w_dbase;
    logic          w_acc;
    logic          w_match;
    logic [15:0]   w_mclk;
    logic [17:0]   w_h3;
    logic [19:0]   w_h9;
    logic [33:0]   w_h4x;
    logic [15:0]   w_vres;

    assign o_busy      = (r_state != S_COLLECT);
    assign o_cfg_ready = !o_busy;
    assign acc_in      = i_start && !o_busy;
    assign w_off       = i_first_byte ? '0 : r_off;

    edid_store #(.BLOCK_BYTES(BLOCK_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (acc_in),
        .i_waddr (w_off),
        .i_wdata (i_edid_byte),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    // Header byte check
    always_comb begin
        want = (w_off == '0 || w_off == AW'(7)) ? 8'h00 : 8'hff;
        w_hdr_ok = (i_first_byte ? 1'b1 : r_hdr) &&
                   ((w_off >= AW'(8)) || (i_edid_byte == want));
    end

    // Descriptor base: 0x36 + 18 * index
    assign w_dbase = edid_pkg::DESC_BASE + 8'({r_desc, 4'b0000} + {r_desc, 1'b0});

    // Read address sequencing; r_step counts issued reads within the current state, descriptor or timing slot
    always_comb begin
        n_rreq = 1'b0;
        n_rtag = '0;
        w_a8   = '0;
        n_step = r_step;
        case (r_state)
            S_FIXED: begin
                if (r_step < 6'd30) begin
                    n_rreq = 1'b1;
                    w_a8   = 8'h08 + {2'b00, r_step};
                    n_rtag = r_step[4:0];
                    n_step = r_step + 6'd1;
                end
            end
            S_DESC: begin
                if (r_step < 6'd5) begin
                    n_rreq = 1'b1;
                    w_a8   = w_dbase + ((r_step == 6'd4) ? 8'd9 : {2'b00, r_step});
                    n_rtag = r_step[4:0];
                    n_step = r_step + 6'd1;
                end
            end
            S_RANGE: begin
                if (r_step < 6'd4) begin
                    n_rreq = 1'b1;
                    w_a8   = r_fbase + 8'd5 + {2'b00, r_step};
                    n_rtag = r_step[4:0];
                    n_step = r_step + 6'd1;
                end
            end
            S_TIMING: begin
                if (r_step < 6'd2) begin
                    n_rreq = 1'b1;
                    w_a8   = edid_pkg::TIMING_BASE + {4'd0, r_slot, 1'b0} + {7'd0, r_step[0]};
                    n_rtag = r_step[4:0];
                    n_step = r_step + 6'd1;
                end
            end
            default: ;
        endcase
        n_raddr = w_a8[AW-1:0];
    end

    assign w_acc   = ((!r_req_cks) || (r_sum == 8'd0)) && (r_skip_hdr || r_hdr);
    assign w_match = (r_dsc[0] == 8'h00) && (r_dsc[1] == 8'h00) && (r_dsc[2] == 8'h00) &&
                     (r_dsc[3] == edid_pkg::RANGE_TAG);
    assign w_mclk  = (r_dsc[4] == 8'hff) ? 16'd0 : {8'd0, r_dsc[4]} * 16'd10;

    // Vertical size from aspect; divide by five as a reciprocal multiply
    assign w_h3  = 18'(r_h) * 18'd3;
    assign w_h9  = 20'(r_h) * 20'd9;
    assign w_h4x = 34'({r_h, 2'b00}) * 34'd52429;
    always_comb begin
        case (r_asp)
            2'd0:    w_vres = r_h;
            2'd1:    w_vres = w_h3[17:2];
            2'd2:    w_vres = w_h4x[33:18];
            default: w_vres = w_h9[19:4];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_off       <= '0;
            r_sum       <= '0;
            r_hdr       <= 1'b1;
            r_req_cks   <= 1'b0;
            r_skip_hdr  <= 1'b0;
            r_step      <= '0;
            r_rvalid    <= 1'b0;
            r_res.valid <= 1'b0;
            r_hpend     <= 1'b0;
        end else begin
            r_res.valid <= 1'b0;
            r_rvalid    <= n_rreq;
            r_rtag      <= n_rtag;
            r_step      <= n_step;
            r_hpend     <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == edid_pkg::REG_REQ_CKS) r_req_cks <= i_cfg_data;
                else                                    r_skip_hdr <= i_cfg_data;
            end
            case (r_state)
                S_COLLECT: begin
                    r_step <= '0;
                    if (acc_in) begin
                        r_sum <= (i_first_byte ? 8'd0 : r_sum) + i_edid_byte;
                        r_hdr <= w_hdr_ok;
                        if (w_off == AW'(BLOCK_BYTES - 1)) begin
                            r_off   <= '0;
                            r_state <= S_FIXED;
                        end else begin
                            r_off <= w_off + AW'(1);
                        end
                    end
                end
                S_FIXED: begin
                    if (r_rvalid) r_b[r_rtag] <= w_rdata;
                    if (r_step == 6'd30 && !r_rvalid) begin
                        r_res.valid <= 1'b1;
                        r_res.kind  <= edid_pkg::KIND_STATUS;
                        r_res.a     <= {15'd0, w_acc};
                        r_res.b     <= {15'd0, r_hdr};
                        r_res.c     <= {31'd0, (r_sum == 8'd0)};
                        r_res.d     <= {r_b[10], r_b[11]};
                        r_res.last  <= 1'b0;
                        r_state     <= S_IDENT;
                    end
                end
                S_IDENT: begin
                    r_res.valid <= 1'b1;
                    r_res.kind  <= edid_pkg::KIND_IDENT;
                    r_res.a     <= {r_b[0], r_b[1]};
                    r_res.b     <= {r_b[3], r_b[2]};
                    r_res.c     <= {r_b[7], r_b[6], r_b[5], r_b[4]};
                    r_res.d     <= '0;
                    r_res.last  <= 1'b0;
                    r_state     <= S_DATE;
                end
                S_DATE: begin
                    r_res.valid <= 1'b1;
                    r_res.kind  <= edid_pkg::KIND_DATE;
                    r_res.a     <= {8'd0, r_b[9]} + 16'd1990;
                    r_res.b     <= {8'd0, r_b[8]};
                    r_res.c     <= {24'd0, r_b[14]};
                    r_res.d     <= {8'd0, r_b[13]};
                    r_res.last  <= 1'b0;
                    r_state     <= S_DESC;
                    r_step      <= '0;
                    r_desc      <= '0;
                    r_found     <= 1'b0;
                end
                S_DESC: begin
                    if (r_rvalid) r_dsc[r_rtag[2:0]] <= w_rdata;
                    if (r_step == 6'd5 && !r_rvalid) begin
                        if (w_match || (32'(r_desc) == DESCRIPTOR_COUNT - 1)) begin
                            r_res.valid <= 1'b1;
                            r_res.kind  <= edid_pkg::KIND_DISP;
                            r_res.a     <= {8'd0, r_b[15]} + 16'd100;
                            r_res.b     <= {8'd0, r_b[16]};
                            r_res.c     <= {8'd0, r_b[29], r_b[28], r_b[27]};
                            r_res.d     <= w_match ? w_mclk : 16'd0;
                            r_res.last  <= 1'b0;
                            r_found     <= w_match;
                            r_fbase     <= w_dbase;
                            r_state     <= S_RANGE;
                            r_step      <= w_match ? 6'd0 : 6'd4;
                        end else begin
                            r_desc <= r_desc + 2'd1;
                            r_step <= '0;
                        end
                    end
                end
                S_RANGE: begin
                    if (r_rvalid) r_rng[r_rtag[1:0]] <= w_rdata;
                    if (r_step == 6'd4 && !r_rvalid) begin
                        r_res.valid <= 1'b1;
                        r_res.kind  <= edid_pkg::KIND_LIMITS;
                        r_res.a     <= r_found ? {8'd0, r_rng[0]} : 16'd0;
                        r_res.b     <= r_found ? {8'd0, r_rng[1]} : 16'd0;
                        r_res.c     <= r_found ? {24'd0, r_rng[2]} : 32'd0;
                        r_res.d     <= r_found ? {8'd0, r_rng[3]} : 16'd0;
                        r_res.last  <= 1'b0;
                        r_state     <= S_TIMING;
                        r_step      <= '0;
                        r_slot      <= '0;
                    end
                end
                S_TIMING: begin
                    if (r_rvalid && r_rtag == 5'd0) r_t0 <= w_rdata;
                    if (r_rvalid && r_rtag == 5'd1) begin
                        r_used  <= ((r_t0 | w_rdata) & 8'hfe) != 8'd0;
                        r_h     <= (16'(r_t0) + 16'd31) << 3;
                        r_asp   <= w_rdata[7:6];
                        r_rf    <= w_rdata[5:0];
                        r_hpend <= 1'b1;
                    end
                    if (r_hpend) begin
                        r_res.valid <= 1'b1;
                        r_res.kind  <= edid_pkg::KIND_TIMING;
                        r_res.a     <= r_used ? r_h : 16'd0;
                        r_res.b     <= r_used ? w_vres : 16'd0;
                        r_res.c     <= r_used ? {26'd0, r_rf} + 32'd60 : 32'd0;
                        r_res.d     <= {13'd0, r_slot};
                        r_res.last  <= (32'(r_slot) == TIMING_SLOTS - 1);
                        if (32'(r_slot) == TIMING_SLOTS - 1) begin
                            r_state <= S_COLLECT;
                            r_sum   <= '0;
                            r_hdr   <= 1'b1;
                        end else begin
                            r_slot <= r_slot + 3'd1;
                            r_step <= '0;
                        end
                    end
                end
                default: r_state <= S_COLLECT;
            endcase
        end
    end

    assign o_strobe  = r_res.valid;
    assign o_kind    = r_res.kind;
    assign o_value_a = r_res.a;
    assign o_value_b = r_res.b;
    assign o_value_c = r_res.c;
    assign o_value_d = r_res.d;
    assign o_last    = r_res.last;
endmodule
